### hdl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

  // Most code units one input byte can produce: three flushed bytes plus
  // one more for a lead that is cut off by the end of the string.
  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] ReplUnit   = 16'hFFFD;
  localparam logic [15:0] SurHiBase  = 16'hD800;
  localparam logic [15:0] SurLoBase  = 16'hDC00;
  localparam logic [20:0] SuppOffset = 21'h10000;
  localparam logic [9:0]  SurLoMask  = 10'h3FF;

  // Pending sequence length codes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // One queued output code unit
  typedef struct packed {
    logic [15:0] unit;
    logic        repl;
  } unit_slot_t;

  // High surrogate of a supplementary code point (no range check)
  function automatic logic [15:0] sur_hi(input logic [20:0] cp);
    logic [20:0] v;
    v = cp - SuppOffset;
    return SurHiBase + {5'd0, v[20:10]};
  endfunction

  function automatic logic [15:0] sur_lo(input logic [20:0] cp);
    logic [20:0] v;
    v = cp - SuppOffset;
    return SurLoBase + {6'd0, v[9:0] & SurLoMask};
  endfunction

endpackage

### hdl/utf8_to_utf16_decoder_top.sv
`timescale 1ns / 1ps

// Latency: first code unit of a byte appears the cycle after its transaction.
// Throughput: one byte per cycle while unstalled and each byte gives at most
// one unit; a byte of more units (up to 4) holds the register until drained.
// Bytes giving no unit (lead/middle bytes) never occupy the output register.
// Reset (rst_ni low, async): no sequence pending, output register empty.
module utf8_to_utf16_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic        m_axis_tuser_o,   // replaced
  output logic        m_axis_tlast_o    // run_last
);

  // ---------------------------------------------------------------------
  // Decoder state: the partially collected UTF-8 sequence
  // ---------------------------------------------------------------------
  logic [2:0]  seq_len_q, seq_len_d;
  logic [1:0]  seq_cnt_q, seq_cnt_d;
  logic [20:0] seq_pv_q,  seq_pv_d;

  // ---------------------------------------------------------------------
  // Result register: all units of one byte, drained one per transaction
  // ---------------------------------------------------------------------
  u8u16_pkg::unit_slot_t slot_q [u8u16_pkg::MaxUnits];
  u8u16_pkg::unit_slot_t slot_d [u8u16_pkg::MaxUnits];
  logic [2:0] res_cnt_q, res_cnt_d;   // units held, 1..4 when valid
  logic [1:0] idx_q;                  // next unit to present
  logic       out_valid_q;

  logic s_fire, m_fire, out_last;

  // Decode intermediates
  logic        is_cont;
  logic        lead_step;
  logic [1:0]  pre_n;       // flushed units from a broken sequence
  logic [1:0]  main_n;      // units of the decoded point or bad lead
  logic [1:0]  post_n;      // flushed units at end of string
  logic        main_repl;
  logic [20:0] main_cp;
  logic [15:0] main_u0, main_u1;
  logic [2:0]  pre_main;

  assign out_last = out_valid_q && ({1'b0, idx_q} == (res_cnt_q - 3'd1));
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  // Take a byte when the result register is empty or drains this cycle.
  assign s_axis_tready_o = !out_valid_q || (m_axis_tready_i && out_last);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------
  // Byte decode and next state
  // ---------------------------------------------------------------------
  always_comb begin
    seq_len_d = seq_len_q;
    seq_cnt_d = seq_cnt_q;
    seq_pv_d  = seq_pv_q;
    pre_n     = 2'd0;
    main_n    = 2'd0;
    post_n    = 2'd0;
    main_repl = 1'b0;
    main_cp   = '0;
    lead_step = 1'b0;
    is_cont   = (s_axis_tdata_i[7:6] == 2'b10);

    if (seq_len_q == u8u16_pkg::LenNone) begin
      lead_step = 1'b1;
    end else if (is_cont) begin
      seq_pv_d  = {seq_pv_q[14:0], s_axis_tdata_i[5:0]};
      seq_cnt_d = seq_cnt_q + 2'd1;
      // count wraps to zero after the fourth byte of a 4-byte sequence
      if (({1'b0, seq_cnt_d} >= seq_len_q) || (seq_cnt_d == 2'd0)) begin
        main_cp   = seq_pv_d;
        main_n    = (seq_pv_d[20:16] != 5'd0) ? 2'd2 : 2'd1;
        seq_len_d = u8u16_pkg::LenNone;
        seq_cnt_d = 2'd0;
        seq_pv_d  = '0;
      end
    end else begin
      // broken sequence: one replacement per collected byte, then re-lead
      pre_n     = seq_cnt_q;
      seq_len_d = u8u16_pkg::LenNone;
      seq_cnt_d = 2'd0;
      seq_pv_d  = '0;
      lead_step = 1'b1;
    end

    if (lead_step) begin
      case (s_axis_tdata_i) inside
        [8'h00:8'h7F]: begin
          main_cp = {13'd0, s_axis_tdata_i};
          main_n  = 2'd1;
        end
        [8'hC0:8'hDF]: begin
          seq_len_d = u8u16_pkg::Len2;
          seq_cnt_d = 2'd1;
          seq_pv_d  = {16'd0, s_axis_tdata_i[4:0]};
        end
        [8'hE0:8'hEF]: begin
          seq_len_d = u8u16_pkg::Len3;
          seq_cnt_d = 2'd1;
          seq_pv_d  = {17'd0, s_axis_tdata_i[3:0]};
        end
        [8'hF0:8'hF7]: begin
          seq_len_d = u8u16_pkg::Len4;
          seq_cnt_d = 2'd1;
          seq_pv_d  = {18'd0, s_axis_tdata_i[2:0]};
        end
        default: begin
          // stray continuation or invalid lead
          main_n    = 2'd1;
          main_repl = 1'b1;
        end
      endcase
    end

    if (s_axis_tlast_i && (seq_len_d != u8u16_pkg::LenNone)) begin
      post_n    = seq_cnt_d;
      seq_len_d = u8u16_pkg::LenNone;
      seq_cnt_d = 2'd0;
      seq_pv_d  = '0;
    end
  end

  // Units of the main result: BMP value, surrogate pair or replacement
  always_comb begin
    if (main_repl) begin
      main_u0 = u8u16_pkg::ReplUnit;
      main_u1 = u8u16_pkg::ReplUnit;
    end else if (main_n == 2'd2) begin
      main_u0 = u8u16_pkg::sur_hi(main_cp);
      main_u1 = u8u16_pkg::sur_lo(main_cp);
    end else begin
      main_u0 = main_cp[15:0];
      main_u1 = main_cp[15:0];
    end
  end

  // Lay out the units in order: flushed, main, end-of-string flushed
  assign pre_main  = {1'b0, pre_n} + {1'b0, main_n};
  assign res_cnt_d = pre_main + {1'b0, post_n};

  always_comb begin
    for (int j = 0; j < u8u16_pkg::MaxUnits; j++) begin
      if (3'(j) < {1'b0, pre_n}) begin
        slot_d[j] = '{unit: u8u16_pkg::ReplUnit, repl: 1'b1};
      end else if (3'(j) < pre_main) begin
        if (3'(j) == {1'b0, pre_n}) begin
          slot_d[j] = '{unit: main_u0, repl: main_repl};
        end else begin
          slot_d[j] = '{unit: main_u1, repl: main_repl};
        end
      end else begin
        slot_d[j] = '{unit: u8u16_pkg::ReplUnit, repl: 1'b1};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= u8u16_pkg::LenNone;
      seq_cnt_q <= 2'd0;
      seq_pv_q  <= '0;
    end else if (s_fire) begin
      seq_len_q <= seq_len_d;
      seq_cnt_q <= seq_cnt_d;
      seq_pv_q  <= seq_pv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      res_cnt_q   <= 3'd0;
    end else if (s_fire && (res_cnt_d != 3'd0)) begin
      out_valid_q <= 1'b1;
      idx_q       <= 2'd0;
      res_cnt_q   <= res_cnt_d;
    end else if (m_fire) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire && (res_cnt_d != 3'd0)) begin
      for (int j = 0; j < u8u16_pkg::MaxUnits; j++) begin
        slot_q[j] <= slot_d[j];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = slot_q[idx_q].unit;
  assign m_axis_tuser_o  = slot_q[idx_q].repl;
  assign m_axis_tlast_o  = out_last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_only_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> (!out_valid_q || (m_fire && out_last)))
    else $error("byte accepted while earlier units still pending");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_cnt_q != 3'd0) && ({1'b0, idx_q} < res_cnt_q))
    else $error("output index beyond held units");

  a_idx_holds_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> out_valid_q && $stable(idx_q))
    else $error("output unit changed during stall");

  a_seq_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q == u8u16_pkg::LenNone) |-> (seq_cnt_q == 2'd0))
    else $error("count nonzero with no sequence pending");

  a_seq_partial : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q != u8u16_pkg::LenNone) |->
      (seq_cnt_q != 2'd0) && ({1'b0, seq_cnt_q} < seq_len_q))
    else $error("pending sequence count out of range");

endmodule
